[src/csse_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csse_pkg
// Shared types, constants and basis tables for the cubic spline segment
// evaluation unit.
// ----------------------------------------------------------------------------
package csse_pkg;

  // Fixed formats: coordinates signed Q7.8, t unsigned Q0.16 with 1.0 included
  localparam int CoordBits = 16;
  localparam int TFracBits = 16;
  localparam int TW        = TFracBits + 1;
  localparam int NumCoords = 3;
  localparam int NumOps    = 4;
  localparam int NumTerms  = 4;
  localparam int PackW     = NumCoords * CoordBits;

  localparam logic [TW-1:0] TOne  = TW'(1) << TFracBits;
  localparam logic [TW-1:0] THalf = TW'(1) << (TFracBits - 1);

  // Six times a basis weight stays below 78 * 2^16 in magnitude
  localparam int CoefW   = 7;
  localparam int W6W     = 24;
  localparam int ProdW   = W6W + CoordBits;
  localparam int SumW    = ProdW + 2;
  localparam int ScaledW = SumW + 1 - TFracBits;

  // In-range scaled sums lie in [6*min, 6*max+5]
  localparam logic signed [ScaledW-1:0] ScaledMin =
      -(ScaledW'(6) <<< (CoordBits - 1));
  localparam logic signed [ScaledW-1:0] ScaledMax =
      (ScaledW'(6) <<< (CoordBits - 1)) - ScaledW'(1);
  localparam logic signed [SumW:0] RoundOff = (SumW + 1)'(3) << TFracBits;

  // Divide by six: q = (u * ceil(2^22 / 6)) >> 22, exact for u < 2^21
  localparam int UW         = CoordBits + 3;
  localparam int RecipW     = 20;
  localparam int RecipShift = 22;
  localparam logic [RecipW-1:0] RecipMul = 20'd699051;
  localparam int QuotW      = UW + RecipW;

  localparam logic signed [CoordBits-1:0] PosMin = {1'b1, {(CoordBits-1){1'b0}}};
  localparam logic signed [CoordBits-1:0] PosMax = {1'b0, {(CoordBits-1){1'b1}}};

  // Pipeline stage indices
  localparam int StgIn     = 0;
  localparam int StgSq     = 1;
  localparam int StgCube   = 2;
  localparam int StgWgt    = 3;
  localparam int StgProd   = 4;
  localparam int StgSum    = 5;
  localparam int StgDiv    = 6;
  localparam int StgOut    = 7;
  localparam int NumStages = 8;

  typedef logic [NumStages-1:0] csse_adv_t;
  typedef logic signed [W6W-1:0] csse_w6_t;

  typedef enum logic [1:0] {
    BasisBezier     = 2'd0,
    BasisHermite    = 2'd1,
    BasisCatmullRom = 2'd2,
    BasisBspline    = 2'd3
  } csse_basis_e;

  typedef struct packed {
    logic [TW-1:0]    t_param;
    logic [PackW-1:0] begin_point;
    logic [PackW-1:0] end_point;
    logic [PackW-1:0] begin_tangent;
    logic [PackW-1:0] end_tangent;
  } csse_in_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] pos_x;
    logic signed [CoordBits-1:0] pos_y;
    logic signed [CoordBits-1:0] pos_z;
  } csse_out_t;

  // Six times each basis coefficient: [basis][operand][t3, t2, t, 1]
  localparam logic signed [CoefW-1:0] Coef6 [4][NumOps][NumTerms] = '{
    '{ '{-7'sd6,   7'sd18, -7'sd18,  7'sd6},
       '{ 7'sd6,   7'sd0,   7'sd0,   7'sd0},
       '{ 7'sd18, -7'sd36,  7'sd18,  7'sd0},
       '{-7'sd18,  7'sd18,  7'sd0,   7'sd0} },
    '{ '{ 7'sd12, -7'sd18,  7'sd0,   7'sd6},
       '{-7'sd12,  7'sd18,  7'sd0,   7'sd0},
       '{ 7'sd6,  -7'sd12,  7'sd6,   7'sd0},
       '{ 7'sd6,  -7'sd6,   7'sd0,   7'sd0} },
    '{ '{-7'sd3,   7'sd6,  -7'sd3,   7'sd0},
       '{ 7'sd9,  -7'sd15,  7'sd0,   7'sd6},
       '{-7'sd9,   7'sd12,  7'sd3,   7'sd0},
       '{ 7'sd3,  -7'sd3,   7'sd0,   7'sd0} },
    '{ '{-7'sd1,   7'sd3,  -7'sd3,   7'sd1},
       '{ 7'sd3,  -7'sd6,   7'sd0,   7'sd4},
       '{-7'sd3,   7'sd3,   7'sd3,   7'sd1},
       '{ 7'sd1,   7'sd0,   7'sd0,   7'sd0} }
  };

endpackage
`default_nettype wire

[src/cubic_spline_segment_eval_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_spline_segment_eval_unit
// Evaluates one cubic segment (Bezier, Hermite, Catmull-Rom, B-spline) at t.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries t and the four control
//   operands; a transaction completes on an edge with valid high, stall low.
//   Output channel out_valid_o / out_stall_i returns x, y, z of the curve
//   point, one result per input transaction, in order.
//   cfg_we_i writes cfg_wdata_i into the basis select register; change it
//   only while no transaction is in flight.
//   A transaction passes eight register stages, StgIn to StgOut, on its way
//   to out_valid_o. Throughput: one transaction per cycle unless stalled,
//   set by the pipelined multipliers (t^2, t^3, weight products, divide).
//   Reset empties the pipeline and selects the Bezier basis.
//   When the receiver stalls, the output holds; stages behind it keep
//   filling empty slots, and in_stall_o rises once every stage is full.
// ----------------------------------------------------------------------------
module cubic_spline_segment_eval_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire csse_pkg::csse_in_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output csse_pkg::csse_out_t       out_data_o
);
  import csse_pkg::*;

  csse_basis_e      basis_q, basis0_q;
  logic [NumStages-1:0] valid_q;
  csse_adv_t        adv;
  logic [TW-1:0]    t_clamp, t0_q;
  logic [PackW-1:0] ops_in [NumOps];
  logic [PackW-1:0] ops_q  [StgWgt+1][NumOps];
  csse_w6_t         w6     [NumOps];
  logic signed [CoordBits-1:0] lane_coord [NumCoords][NumOps];
  logic signed [CoordBits-1:0] lane_pos   [NumCoords];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      basis_q <= BasisBezier;
    end else if (cfg_we_i) begin
      basis_q <= csse_basis_e'(cfg_wdata_i);
    end
  end

  // A stage loads when it is empty or the next one loads
  always_comb begin
    adv[StgOut] = !valid_q[StgOut] || !out_stall_i;
    for (int n = StgOut - 1; n >= 0; n--) begin
      adv[n] = !valid_q[n] || adv[n+1];
    end
  end

  assign in_stall_o = !adv[StgIn];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[StgIn]) begin
        valid_q[StgIn] <= in_valid_i;
      end
      for (int n = StgSq; n < NumStages; n++) begin
        if (adv[n]) begin
          valid_q[n] <= valid_q[n-1];
        end
      end
    end
  end

  // Stage 0: capture with t clamped to one
  assign t_clamp = (in_data_i.t_param > TOne) ? TOne : in_data_i.t_param;

  always_comb begin
    ops_in[0] = in_data_i.begin_point;
    ops_in[1] = in_data_i.end_point;
    ops_in[2] = in_data_i.begin_tangent;
    ops_in[3] = in_data_i.end_tangent;
  end

  always_ff @(posedge clk_i) begin
    if (adv[StgIn]) begin
      t0_q     <= t_clamp;
      basis0_q <= basis_q;
      ops_q[StgIn] <= ops_in;
    end
    for (int n = StgSq; n <= StgWgt; n++) begin
      if (adv[n]) begin
        ops_q[n] <= ops_q[n-1];
      end
    end
  end

  csse_weight u_weight (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .wgt_valid_i (valid_q[StgWgt]),
    .t_i         (t0_q),
    .basis_i     (basis0_q),
    .w6_o        (w6)
  );

  always_comb begin
    for (int k = 0; k < NumCoords; k++) begin
      for (int i = 0; i < NumOps; i++) begin
        lane_coord[k][i] = ops_q[StgWgt][i][k*CoordBits +: CoordBits];
      end
    end
  end

  for (genvar k = 0; k < NumCoords; k++) begin : g_lane
    csse_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .out_valid_i (valid_q[StgDiv]),
      .w6_i        (w6),
      .coord_i     (lane_coord[k]),
      .pos_o       (lane_pos[k])
    );
  end

  assign out_valid_o      = valid_q[StgOut];
  assign out_data_o.pos_x = lane_pos[0];
  assign out_data_o.pos_y = lane_pos[1];
  assign out_data_o.pos_z = lane_pos[2];

`ifndef SYNTHESIS
  // Input backs up only when the whole pipeline is full behind a stalled output
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q && out_stall_i))
    else $error("input stalled with an empty pipeline slot");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[StgIn])
    else $error("accepted transaction lost at entry");

  // A stalled result is kept until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");
`endif

endmodule
`default_nettype wire

[src/csse_weight.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csse_weight
// Forms t^2 and t^3 over two multiplier stages, then the four basis weights
// (scaled by six) in a third stage.
// ----------------------------------------------------------------------------
module csse_weight (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire csse_pkg::csse_adv_t     adv_i,
  input  wire logic                    wgt_valid_i,
  input  wire logic [csse_pkg::TW-1:0] t_i,
  input  wire csse_pkg::csse_basis_e   basis_i,
  output csse_pkg::csse_w6_t           w6_o [csse_pkg::NumOps]
);
  import csse_pkg::*;

  logic [TW-1:0]   t1_q, t2_q;
  logic [2*TW-1:0] tt_q, t2t_q;
  logic [TW-1:0]   tsq_q;
  csse_basis_e     basis1_q, basis2_q, basis3_q;
  logic [2*TW:0]   tt_rnd, t2t_rnd;
  logic [TW-1:0]   tsq_d, tcube;
  csse_w6_t        w6_d [NumOps];
  csse_w6_t        w6_q [NumOps];

  // Stage 1: t squared, raw
  always_ff @(posedge clk_i) begin
    if (adv_i[StgSq]) begin
      t1_q     <= t_i;
      tt_q     <= t_i * t_i;
      basis1_q <= basis_i;
    end
  end

  // Stage 2: round t^2, then t^2 * t raw
  always_comb begin
    tt_rnd = {1'b0, tt_q} + (2*TW+1)'(THalf);
    tsq_d  = tt_rnd[TFracBits +: TW];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[StgCube]) begin
      t2_q     <= t1_q;
      tsq_q    <= tsq_d;
      t2t_q    <= tsq_d * t1_q;
      basis2_q <= basis1_q;
    end
  end

  // Stage 3: round t^3, weights w6 = a*t3 + b*t2 + c*t + d*one
  always_comb begin
    logic signed [W6W+3:0] acc;
    t2t_rnd = {1'b0, t2t_q} + (2*TW+1)'(THalf);
    tcube   = t2t_rnd[TFracBits +: TW];
    for (int i = 0; i < NumOps; i++) begin
      acc = Coef6[basis2_q][i][0] * $signed({1'b0, tcube})
          + Coef6[basis2_q][i][1] * $signed({1'b0, tsq_q})
          + Coef6[basis2_q][i][2] * $signed({1'b0, t2_q})
          + Coef6[basis2_q][i][3] * $signed({1'b0, TOne});
      w6_d[i] = acc[W6W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[StgWgt]) begin
      w6_q     <= w6_d;
      basis3_q <= basis2_q;
    end
  end

  assign w6_o = w6_q;

`ifndef SYNTHESIS
  // Interpolating and approximating bases (not Hermite) form a partition of unity
  a_unity_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wgt_valid_i && basis3_q != BasisHermite) |->
      ((W6W+2)'(w6_q[0]) + (W6W+2)'(w6_q[1]) + (W6W+2)'(w6_q[2]) + (W6W+2)'(w6_q[3])
        == ((W6W+2)'(6) << TFracBits)))
    else $error("basis weights do not sum to one");
`endif

endmodule
`default_nettype wire

[src/csse_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csse_lane
// One coordinate lane: weight products, sum with rounding, divide by six by
// reciprocal multiply, saturate into the output register.
// ----------------------------------------------------------------------------
module csse_lane (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire csse_pkg::csse_adv_t                 adv_i,
  input  wire logic                                out_valid_i,
  input  wire csse_pkg::csse_w6_t                  w6_i    [csse_pkg::NumOps],
  input  wire logic signed [csse_pkg::CoordBits-1:0] coord_i [csse_pkg::NumOps],
  output logic signed [csse_pkg::CoordBits-1:0]    pos_o
);
  import csse_pkg::*;

  logic signed [ProdW-1:0]   prod_q [NumOps];
  logic signed [SumW:0]      sum_d;
  logic signed [ScaledW-1:0] scaled_q;
  logic signed [ScaledW-1:0] biased;
  logic [QuotW-1:0]          quot_q;
  logic                      lo_q, hi_q;
  logic [CoordBits-1:0]      quot;
  logic signed [CoordBits-1:0] pos_d, pos_q;

  // Stage 4: one product per operand
  always_ff @(posedge clk_i) begin
    if (adv_i[StgProd]) begin
      for (int i = 0; i < NumOps; i++) begin
        prod_q[i] <= w6_i[i] * coord_i[i];
      end
    end
  end

  // Stage 5: sum plus half of six, scaled down by 2^T (floor)
  always_comb begin
    sum_d = RoundOff;
    for (int i = 0; i < NumOps; i++) begin
      sum_d = sum_d + (SumW+1)'(prod_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[StgSum]) begin
      scaled_q <= sum_d[SumW:TFracBits];
    end
  end

  // Stage 6: range check and reciprocal multiply on the biased value
  assign biased = scaled_q - ScaledMin;

  always_ff @(posedge clk_i) begin
    if (adv_i[StgDiv]) begin
      lo_q   <= scaled_q < ScaledMin;
      hi_q   <= scaled_q > ScaledMax;
      quot_q <= biased[UW-1:0] * RecipMul;
    end
  end

  // Stage 7: remove the bias (flip the sign bit) or saturate
  always_comb begin
    quot = quot_q[RecipShift +: CoordBits];
    if (hi_q) begin
      pos_d = PosMax;
    end else if (lo_q) begin
      pos_d = PosMin;
    end else begin
      pos_d = {~quot[CoordBits-1], quot[CoordBits-2:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[StgOut]) begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

`ifndef SYNTHESIS
  // An in-range value must divide to a quotient that fits the coordinate width
  a_quot_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !lo_q && !hi_q) |-> (quot_q[QuotW-1:RecipShift+CoordBits] == '0))
    else $error("divide-by-six quotient overflow");
`endif

endmodule
`default_nettype wire
